FILE: design/ple_pkg.sv
package ple_pkg;

  localparam int CAPACITY   = 64;
  localparam int ITEM_WIDTH = 32;

  // Fixed field widths of the request and result items.
  localparam int FUNC_W   = 2;
  localparam int POS_W    = 8;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [FUNC_W-1:0] {
    FN_RETRIEVE = 2'd0,
    FN_INSERT   = 2'd1,
    FN_REMOVE   = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                  shift_up;
    logic                  shift_down;
    logic                  rd;
    logic [IDX_W-1:0]      tgt;
    logic [ITEM_WIDTH-1:0] item;
  } cell_cmd_t;

endpackage

FILE: design/ple_if.sv
interface ple_req_if;
  logic                        valid;
  logic                        ready;
  logic [ple_pkg::FUNC_W-1:0]  func;
  logic [ple_pkg::POS_W-1:0]   position;
  logic [ple_pkg::DATA_W-1:0]  item_in;

  modport source (output valid, output func, output position, output item_in, input ready);
  modport sink   (input valid, input func, input position, input item_in, output ready);
endinterface

interface ple_res_if;
  logic                          valid;
  logic                          ready;
  logic [ple_pkg::DATA_W-1:0]    item_out;
  logic [ple_pkg::STATUS_W-1:0]  status;
  logic [ple_pkg::CNT_W-1:0]     length;
  logic                          empty_res;

  modport source (output valid, output item_out, output status, output length,
                  output empty_res, input ready);
  modport sink   (input valid, input item_out, input status, input length,
                  input empty_res, output ready);
endinterface

FILE: design/positional_list_engine.sv
// Ordered list of up to CAPACITY items addressed by one-based position.
// Requests arrive on in_ch (func, position, item_in) with a valid/ready
// handshake; each accepted item yields exactly one result item on out_ch
// (item_out, status, length, empty_res) in request order.
// Retrieve returns the item at the position; insert takes positions 1 to
// length+1 and moves the later items up; remove takes positions 1 to
// length and closes the gap. An out-of-range position returns status 1,
// an insert into a full list status 2; the list is then unchanged.
// The result is registered and valid in the cycle after acceptance. One item
// is accepted every cycle unless out_ch stalls: every entry sits in a
// cell of its own, and all cells from the position up are rewritten in the
// same cycle, so an insert or remove costs the same at any position.
// The result register is the only buffer; a new item is taken while the
// held result is being taken, and a stalled out_ch stalls in_ch.
// Synchronous reset empties the list and drops any pending result; stored
// entries are not cleared and are never read before they are written.
module positional_list_engine (
  input  logic      clk,
  input  logic      rst_n,
  ple_req_if.sink   in_ch,
  ple_res_if.source out_ch
);
  import ple_pkg::*;

  cell_cmd_t             cmd;
  logic [ITEM_WIDTH-1:0] cell_val [CAPACITY];
  logic [ITEM_WIDTH-1:0] hit_data [CAPACITY];
  logic [ITEM_WIDTH-1:0] rd_data;

  ple_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .rd_data (rd_data),
    .cmd     (cmd)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ITEM_WIDTH-1:0] left_v;
    logic [ITEM_WIDTH-1:0] right_v;

    // End cells take their own value where no neighbor exists.
    if (g == 0) begin : g_first
      assign left_v = cell_val[g];
    end else begin : g_mid_l
      assign left_v = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[g];
    end else begin : g_mid_r
      assign right_v = cell_val[g+1];
    end

    ple_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(g)),
      .cmd       (cmd),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (cell_val[g]),
      .hit_data  (hit_data[g])
    );
  end

  // At most one cell drives a nonzero hit, so an OR merges them.
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | hit_data[i];
    end
  end

endmodule

FILE: design/ple_cell.sv
module ple_cell (
  input  logic                           clk,
  input  logic [ple_pkg::IDX_W-1:0]      idx,
  input  ple_pkg::cell_cmd_t             cmd,
  input  logic [ple_pkg::ITEM_WIDTH-1:0] left_val,
  input  logic [ple_pkg::ITEM_WIDTH-1:0] right_val,
  output logic [ple_pkg::ITEM_WIDTH-1:0] val,
  output logic [ple_pkg::ITEM_WIDTH-1:0] hit_data
);
  import ple_pkg::*;

  logic [ITEM_WIDTH-1:0] val_r;
  logic [ITEM_WIDTH-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (cmd.shift_up) begin
      if (idx == cmd.tgt) begin
        val_nxt = cmd.item;
      end else if (idx > cmd.tgt) begin
        val_nxt = left_val;
      end
    end else if (cmd.shift_down) begin
      if (idx >= cmd.tgt) begin
        val_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val      = val_r;
  assign hit_data = (cmd.rd && (idx == cmd.tgt)) ? val_r : '0;

endmodule

FILE: design/ple_ctrl.sv
module ple_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  ple_req_if.sink                        in_ch,
  ple_res_if.source                      out_ch,
  input  logic [ple_pkg::ITEM_WIDTH-1:0] rd_data,
  output ple_pkg::cell_cmd_t             cmd
);
  import ple_pkg::*;

  logic                out_valid_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic [DATA_W-1:0]   item_out_r;
  status_t             status_r;
  logic [CNT_W-1:0]    length_r;

  logic                in_fire;
  logic [CMP_W-1:0]    pos_x;
  logic [CMP_W-1:0]    cnt_x;
  logic                pos_zero;
  logic                rng_rd;
  logic                rng_ins;
  logic                full;
  status_t             status_c;
  logic                do_ins;
  logic                do_rem;
  logic                do_rd;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign pos_x    = CMP_W'(in_ch.position);
  assign cnt_x    = CMP_W'(count_r);
  assign pos_zero = (in_ch.position == '0);
  assign rng_rd   = !pos_zero && (pos_x <= cnt_x);
  assign rng_ins  = !pos_zero && (pos_x <= cnt_x + CMP_W'(1));
  assign full     = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    status_c = ST_OK;
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    do_rd    = 1'b0;
    case (func_t'(in_ch.func))
      FN_RETRIEVE: begin
        if (rng_rd) do_rd = 1'b1;
        else        status_c = ST_RANGE;
      end
      FN_INSERT: begin
        if (!rng_ins)  status_c = ST_RANGE;
        else if (full) status_c = ST_FULL;
        else           do_ins = 1'b1;
      end
      FN_REMOVE: begin
        if (rng_rd) do_rem = 1'b1;
        else        status_c = ST_RANGE;
      end
      default: begin
        status_c = ST_OK;
      end
    endcase
  end

  // The target index is only meaningful when the position is in range.
  always_comb begin
    cmd.shift_up   = in_fire && do_ins;
    cmd.shift_down = in_fire && do_rem;
    cmd.rd         = in_fire && do_rd;
    cmd.tgt        = IDX_W'(in_ch.position - POS_W'(1));
    cmd.item       = ITEM_WIDTH'(in_ch.item_in);
  end

  always_comb begin
    count_nxt = count_r;
    if (in_fire && do_ins) count_nxt = count_r + CNT_W'(1);
    else if (in_fire && do_rem) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_out_r <= do_rd ? DATA_W'(rd_data) : '0;
      status_r   <= status_c;
      length_r   <= count_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.item_out  = item_out_r;
  assign out_ch.status    = status_r;
  assign out_ch.length    = length_r;
  assign out_ch.empty_res = (length_r == '0);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("item count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && do_ins) |=> (count_r == CNT_W'($past(count_r) + CNT_W'(1))))
    else $error("insert did not grow the list");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_FULL) |-> (length_r == CNT_W'(CAPACITY)))
    else $error("full status with a list that is not full");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_OK) |-> (item_out_r == '0))
    else $error("failed request returned a nonzero item");

  a_len_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (length_r == count_r))
    else $error("result length differs from the held count");

endmodule
